// ----- hw/rtl/rtpjb_pkg.sv -----
// Package for the RTP sequence jitter buffer: word types, op codes and constants.
// No dependencies; imported by rtpjb_slot_mod and rtp_sequence_jitter_buffer_unit.
`default_nettype none

package rtpjb_pkg;

	localparam int SEQ_W     = 16;
	localparam int LEN_W     = 9;
	localparam int DATA_W    = 64;
	localparam int DELAY_W   = 11;
	localparam int BYTE_W    = 8;
	localparam int WORD_BYTES = DATA_W / BYTE_W;

	localparam int SLOTS_DEF     = 64;
	localparam int MAX_BYTES_DEF = 256;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(60);

	// Frame length in milliseconds; the delay is divided by it through a
	// pre-shift and a reciprocal multiply.
	localparam int FRAME_MS        = 20;
	localparam int MIN_FRAMES      = 1;
	localparam int FRAME_PRE_SHIFT = 2;
	localparam int FRAME_DIV       = FRAME_MS >> FRAME_PRE_SHIFT;
	localparam int FRAME_SHIFT     = 10;
	localparam int FRAME_RECIP     = ((1 << FRAME_SHIFT) + FRAME_DIV - 1) / FRAME_DIV;
	localparam int FRAMES_W        = 7;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SEQ_W-1:0]  seq;
		logic [LEN_W-1:0]  packet_len;
		logic [DATA_W-1:0] data_word;
		logic              last_word;
	} rtpjb_in_t;

	typedef struct packed {
		logic              found;
		logic [SEQ_W-1:0]  played_seq;
		logic [LEN_W-1:0]  frame_len;
		logic [DATA_W-1:0] frame_word;
		logic              last;
	} rtpjb_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtpjb_slot_mod.sv -----
// Two-stage reduction of a sequence number to its slot index (seq mod SLOTS).
// Depends on rtpjb_pkg for the sequence width.
`default_nettype none

module rtpjb_slot_mod
	import rtpjb_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [SEQ_W-1:0]           key,
	output logic      [$clog2(SLOTS)-1:0]   slot
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int RECIP  = (1 << SEQ_W) / SLOTS;

	logic [2*SEQ_W-1:0] prod_s1;
	logic [SEQ_W-1:0]   key_s1;
	logic [SEQ_W-1:0]   quot_est;
	logic [2*SEQ_W-1:0] back;
	logic [SEQ_W-1:0]   rem_est;
	logic [SEQ_W-1:0]   rem_fix;
	logic [SLOT_W-1:0]  slot_s2;

	// The truncated reciprocal gives a quotient that is exact or one short, so
	// the remainder needs at most one corrective subtraction.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*SEQ_W)'(key) * (2*SEQ_W)'(RECIP);
			key_s1  <= key;
		end
	end

	always_comb begin
		quot_est = prod_s1[2*SEQ_W-1:SEQ_W];
		back     = (2*SEQ_W)'(quot_est) * (2*SEQ_W)'(SLOTS);
		rem_est  = key_s1 - back[SEQ_W-1:0];
		if (rem_est >= SEQ_W'(SLOTS)) begin
			rem_fix = rem_est - SEQ_W'(SLOTS);
		end else begin
			rem_fix = rem_est;
		end
	end

	always_ff @(posedge clk) begin
		slot_s2 <= rem_fix[SLOT_W-1:0];
	end

	assign slot = slot_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/rtp_sequence_jitter_buffer_unit.sv -----
// A put word holds the unit through the slot reduction (ST_MOD) and then the write (ST_EXEC); the next
// word is accepted once the unit is back in ST_IDLE. A get reads the slot header in ST_EXEC and, once the
// output register is free, raises out_valid with silence from ST_HDR, or with its first word from ST_STREAM
// and then one word per cycle while out_ready stays high; the payload memory's single read port sets that.
// Only one item is in flight; the two-stage slot reduction and the execute cycle set the rate. Reset (arst_n
// low) clears slot marks, cursor and word index and sets the initial delay to 60 ms; memories hold no reset.
`default_nettype none

module rtp_sequence_jitter_buffer_unit
	import rtpjb_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rtpjb_in_t          in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rtpjb_out_t              out_data,
	input  wire logic               cfg_we,
	input  wire logic [DELAY_W-1:0] cfg_wdata
);

	localparam int WORDS     = (MAX_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W     = $clog2(WORDS + 1);
	localparam int ADDR_W    = SLOT_W + WIDX_W;
	localparam int PAY_DEPTH = SLOTS << WIDX_W;
	localparam int TAIL_W    = $clog2(WORD_BYTES);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MOD    = 5'b00010,
		ST_EXEC   = 5'b00100,
		ST_HDR    = 5'b01000,
		ST_STREAM = 5'b10000
	} state_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
	} slot_hdr_t;

	state_t                state_q;
	rtpjb_in_t             item_q;
	logic [DELAY_W-1:0]    min_delay_q;
	logic                  started_q;
	logic [SEQ_W-1:0]      cursor_q;
	logic [WIDX_W-1:0]     widx_q;
	logic [SLOTS-1:0]      valid_q;
	logic [SLOTS-1:0]      used_q;
	logic [CNT_W-1:0]      k_q;

	slot_hdr_t             hdr_mem [SLOTS];
	logic [DATA_W-1:0]     pay_mem [PAY_DEPTH];
	slot_hdr_t             hdr_rd_q;
	logic [DATA_W-1:0]     pay_rd_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [SEQ_W-1:0]      out_seq_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [WORD_BYTES-1:0] out_mask_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  out_free;
	logic [SEQ_W-1:0]      key;
	logic [SLOT_W-1:0]     slot;
	logic                  len_ok;
	logic                  put_do;
	logic                  put_commit;
	logic [ADDR_W-1:0]     pay_waddr;
	logic [ADDR_W-1:0]     pay_raddr;
	logic                  pay_re;
	logic                  hit;
	logic [CNT_W-1:0]      nw;
	logic                  last_now;
	logic [TAIL_W-1:0]     tail;
	logic [WORD_BYTES-1:0] mask_now;
	logic [LEN_W-1:0]      delay_q4;
	logic [16:0]           frames_prod;
	logic [FRAMES_W-1:0]   frames_raw;
	logic [FRAMES_W-1:0]   frames;
	logic [DATA_W-1:0]     word_mask;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign key      = (in_data.op == OP_GET) ? cursor_q + SEQ_W'(1) : in_data.seq;

	rtpjb_slot_mod #(
		.SLOTS(SLOTS)
	) u_slot_mod (
		.clk (clk),
		.en  (accept),
		.key (key),
		.slot(slot)
	);

	// Initial delay in whole frames, never below one frame.
	always_comb begin
		delay_q4    = LEN_W'(min_delay_q >> FRAME_PRE_SHIFT);
		frames_prod = 17'(delay_q4) * 17'(FRAME_RECIP);
		frames_raw  = frames_prod[FRAME_SHIFT +: FRAMES_W];
		if (frames_raw < FRAMES_W'(MIN_FRAMES)) begin
			frames = FRAMES_W'(MIN_FRAMES);
		end else begin
			frames = frames_raw;
		end
	end

	always_comb begin
		len_ok     = (item_q.packet_len != '0) && (item_q.packet_len <= LEN_W'(MAX_BYTES));
		put_do     = (state_q == ST_EXEC) && (item_q.op == OP_PUT) && len_ok;
		put_commit = put_do && item_q.last_word;
		pay_waddr  = {slot, widx_q};
		pay_raddr  = {slot, k_q[WIDX_W-1:0]};
		pay_re     = (state_q == ST_STREAM) && out_free;
		hit        = valid_q[slot] && !used_q[slot] && (hdr_rd_q.seq == cursor_q);
		nw         = CNT_W'((10'(hdr_rd_q.len) + 10'd7) >> 3);
		last_now   = ((k_q + CNT_W'(1)) == nw);
		tail       = hdr_rd_q.len[TAIL_W-1:0];
		for (int b = 0; b < WORD_BYTES; b++) begin
			mask_now[b] = !last_now || (tail == '0) || (TAIL_W'(b) < tail);
		end
	end

	always_ff @(posedge clk) begin
		if (put_do) begin
			pay_mem[pay_waddr] <= item_q.data_word;
		end
		if (pay_re) begin
			pay_rd_q <= pay_mem[pay_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (put_commit) begin
			hdr_mem[slot] <= '{seq: item_q.seq, len: item_q.packet_len};
		end
		if ((state_q == ST_EXEC) && (item_q.op == OP_GET)) begin
			hdr_rd_q <= hdr_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			min_delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			cursor_q  <= '0;
			widx_q    <= '0;
			valid_q   <= '0;
			used_q    <= '0;
			k_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.op == OP_GET) begin
							cursor_q <= key;
						end
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					unique case (item_q.op)
						OP_PUT: begin
							if (len_ok) begin
								if (widx_q == '0) begin
									valid_q[slot] <= 1'b0;
								end
								if (widx_q == WIDX_W'(WORDS - 1)) begin
									widx_q <= '0;
								end else begin
									widx_q <= widx_q + WIDX_W'(1);
								end
							end
							if (item_q.last_word) begin
								widx_q <= '0;
							end
							if (put_commit) begin
								valid_q[slot] <= 1'b1;
								used_q[slot]  <= 1'b0;
								if (!started_q) begin
									cursor_q  <= item_q.seq - SEQ_W'(frames);
									started_q <= 1'b1;
								end
							end
						end
						OP_GET: begin
							state_q <= ST_HDR;
						end
						OP_CLEAR: begin
							valid_q   <= '0;
							used_q    <= '0;
							started_q <= 1'b0;
							widx_q    <= '0;
						end
						OP_NOP: begin
						end
						default: begin
						end
					endcase
				end
				ST_HDR: begin
					if (out_free) begin
						k_q <= '0;
						if (hit) begin
							used_q[slot] <= 1'b1;
							state_q      <= ST_STREAM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STREAM: begin
					if (out_free) begin
						k_q <= k_q + CNT_W'(1);
						if (last_now) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The output word register is the payload memory's read register itself;
	// a silence word is produced by a zero byte mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == ST_HDR) && out_free && !hit) || pay_re) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HDR) && out_free && !hit) begin
			out_found_q <= 1'b0;
			out_seq_q   <= cursor_q;
			out_len_q   <= '0;
			out_mask_q  <= '0;
			out_last_q  <= 1'b1;
		end else if (pay_re) begin
			out_found_q <= 1'b1;
			out_seq_q   <= cursor_q;
			out_len_q   <= hdr_rd_q.len;
			out_mask_q  <= mask_now;
			out_last_q  <= last_now;
		end
	end

	always_comb begin
		for (int b = 0; b < WORD_BYTES; b++) begin
			word_mask[b*BYTE_W +: BYTE_W] = {BYTE_W{out_mask_q[b]}};
		end
	end

	assign out_valid           = out_valid_q;
	assign out_data.found      = out_found_q;
	assign out_data.played_seq = out_seq_q;
	assign out_data.frame_len  = out_len_q;
	assign out_data.frame_word = pay_rd_q & word_mask;
	assign out_data.last       = out_last_q;

`ifndef SYNTHESIS
	a_silence_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_last_q && out_len_q == '0 && out_mask_q == '0))
		else $error("silence word with payload or without last");

	a_commit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		put_commit |=> started_q)
		else $error("committed packet did not start the play cursor");

	a_stream_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> (k_q < nw))
		else $error("word counter ran past the frame length");

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(widx_q) < WORDS))
		else $error("put word index out of range");

	a_stream_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> used_q[slot])
		else $error("streaming slot not marked used");
`endif

endmodule

`default_nettype wire
